// ----- sv/rsi_pkg.sv -----
// Shared types, constants and codes of the relative strength index signal block.
`default_nettype none

package rsi_pkg;

  // Default values of the top-level parameters.
  localparam int MAX_WINDOW_DEFAULT = 64;
  localparam int PRICE_BITS_DEFAULT = 32;

  // Field widths of the item payloads and the configuration port.
  localparam int CLOSE_PRICE_BITS = 32;
  localparam int RSI_BITS         = 15;
  localparam int SIGNAL_BITS      = 2;
  localparam int CFG_INDEX_BITS   = 2;
  localparam int CFG_DATA_BITS    = 15;
  localparam int WINDOW_FIELD_BITS = 7;

  // An index of 100 in 7.8 fixed point.
  localparam logic [RSI_BITS-1:0] FULL_SCALE = 15'd25600;

  // Register reset values.
  localparam int WINDOW_RESET = 14;
  localparam logic [RSI_BITS-1:0] OVERSOLD_RESET   = 15'd7680;
  localparam logic [RSI_BITS-1:0] OVERBOUGHT_RESET = 15'd17920;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW     = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_OVERSOLD   = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_OVERBOUGHT = 2'd2;

  // Trade signal codes.
  localparam logic [SIGNAL_BITS-1:0] SIG_NONE = 2'd0;
  localparam logic [SIGNAL_BITS-1:0] SIG_BUY  = 2'd1;
  localparam logic [SIGNAL_BITS-1:0] SIG_SELL = 2'd2;

  typedef struct packed {
    logic [CLOSE_PRICE_BITS-1:0] close_price;
    logic                        restart;
  } in_item_t;

  typedef struct packed {
    logic [RSI_BITS-1:0]    strength_index;
    logic                   index_ready;
    logic [SIGNAL_BITS-1:0] trade_signal;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic update;
    logic add;
    logic div_start;
    logic finish;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ready;
    logic loss_zero;
    logic div_busy;
    logic out_blocked;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- sv/rsi_divider.sv -----
// Iterative restoring divider that forms floor(25600 * gain / (gain + loss)).
`default_nettype none

module rsi_divider #(
  parameter int SUM_BITS = 38
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [SUM_BITS-1:0]          gain_i,
  input  wire logic [SUM_BITS-1:0]          loss_i,
  output logic                              busy_o,
  output logic [rsi_pkg::RSI_BITS-1:0]      quotient_o
);

  localparam int QB       = rsi_pkg::RSI_BITS;
  localparam int NUM_BITS = SUM_BITS + QB;
  localparam int DEN_BITS = SUM_BITS + 1;
  localparam int REM_BITS = SUM_BITS + 2;
  localparam int CNT_BITS = $clog2(QB + 1);

  logic                busy_q;
  logic [CNT_BITS-1:0] cnt_q;
  logic [REM_BITS-1:0] rem_q, rem_d;
  logic [QB-1:0]       low_q;
  logic [QB-1:0]       quo_q;
  logic [DEN_BITS-1:0] den_q;
  logic [NUM_BITS-1:0] num;
  logic [REM_BITS-1:0] cand;
  logic                take;

  // The numerator is gain times 25600, which is 2^14 + 2^13 + 2^10.
  assign num = (NUM_BITS'(gain_i) << 14) + (NUM_BITS'(gain_i) << 13) +
               (NUM_BITS'(gain_i) << 10);

  assign cand  = {rem_q[REM_BITS-2:0], low_q[QB-1]};
  assign take  = (cand >= REM_BITS'(den_q));
  assign rem_d = take ? (cand - REM_BITS'(den_q)) : cand;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_BITS'(QB);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_BITS'(1);
      if (cnt_q == CNT_BITS'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // The upper numerator bits are already below the divisor, since the ratio is at most one.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= REM_BITS'(num[NUM_BITS-1:QB]);
      low_q <= num[QB-1:0];
      quo_q <= '0;
      den_q <= DEN_BITS'(gain_i) + DEN_BITS'(loss_i);
    end else if (busy_q) begin
      rem_q <= rem_d;
      low_q <= {low_q[QB-2:0], 1'b0};
      quo_q <= {quo_q[QB-2:0], take};
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ----- sv/rsi_datapath.sv -----
// Datapath: configuration registers, change ring, running sums, divider and result register.
`default_nettype none

module rsi_datapath #(
  parameter int MAX_WINDOW = rsi_pkg::MAX_WINDOW_DEFAULT,
  parameter int PRICE_BITS = rsi_pkg::PRICE_BITS_DEFAULT
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [rsi_pkg::CFG_INDEX_BITS-1:0]   cfg_index_i,
  input  wire logic [rsi_pkg::CFG_DATA_BITS-1:0]    cfg_data_i,
  input  wire rsi_pkg::in_item_t                    in_item_i,
  input  wire logic                                 out_stall_i,
  input  wire rsi_pkg::dp_cmd_t                     cmd_i,
  output rsi_pkg::dp_status_t                       status_o,
  output logic                                      out_valid_o,
  output rsi_pkg::out_item_t                        out_item_o
);

  localparam int PTR_BITS   = $clog2(MAX_WINDOW);
  localparam int WIN_BITS   = $clog2(MAX_WINDOW + 1);
  localparam int CNT_BITS   = $clog2(MAX_WINDOW + 2);
  localparam int SUM_BITS   = PRICE_BITS + $clog2(MAX_WINDOW);
  localparam int ENTRY_BITS = PRICE_BITS + 1;
  localparam int RB         = rsi_pkg::RSI_BITS;
  localparam int WIN_RESET  = (rsi_pkg::WINDOW_RESET > MAX_WINDOW) ? MAX_WINDOW
                                                                   : rsi_pkg::WINDOW_RESET;

  logic [WIN_BITS-1:0]   win_q;
  logic [RB-1:0]         oversold_q, overbought_q;
  logic [PRICE_BITS-1:0] price_q, prev_price_q;
  logic [PTR_BITS-1:0]   ptr_q, ptr_d;
  logic [CNT_BITS-1:0]   cnt_q;
  logic [SUM_BITS-1:0]   gain_q, loss_q;
  logic [rsi_pkg::SIGNAL_BITS-1:0] prev_sig_q, sig_d;
  logic [ENTRY_BITS-1:0] change_q, change_d, rd_q;
  logic [ENTRY_BITS-1:0] ring [MAX_WINDOW];
  logic                  out_valid_q;
  rsi_pkg::out_item_t    out_q;

  logic [WIN_BITS-1:0]   win_clamp;
  logic                  win_write, clear;
  logic                  have_prev, window_full;
  logic [SUM_BITS-1:0]   old_gain, old_loss, new_gain, new_loss;
  logic [RB-1:0]         rsi_d, quotient;
  logic                  div_busy;

  // Window writes use the low field bits: zero counts as one, past the ring depth as the depth.
  always_comb begin
    if (32'(cfg_data_i[rsi_pkg::WINDOW_FIELD_BITS-1:0]) > MAX_WINDOW) begin
      win_clamp = WIN_BITS'(MAX_WINDOW);
    end else if (cfg_data_i[rsi_pkg::WINDOW_FIELD_BITS-1:0] == '0) begin
      win_clamp = WIN_BITS'(1);
    end else begin
      win_clamp = WIN_BITS'(cfg_data_i[rsi_pkg::WINDOW_FIELD_BITS-1:0]);
    end
  end

  assign win_write   = cfg_we_i && (cfg_index_i == rsi_pkg::CFG_WINDOW);
  assign clear       = win_write || (cmd_i.accept && in_item_i.restart);
  assign have_prev   = (cnt_q != '0);
  assign window_full = (cnt_q > CNT_BITS'(win_q));

  // A ring entry holds a loss flag above the magnitude of the change.
  assign change_d = (price_q >= prev_price_q) ? {1'b0, price_q - prev_price_q}
                                              : {1'b1, prev_price_q - price_q};
  assign old_gain = rd_q[PRICE_BITS] ? '0 : SUM_BITS'(rd_q[PRICE_BITS-1:0]);
  assign old_loss = rd_q[PRICE_BITS] ? SUM_BITS'(rd_q[PRICE_BITS-1:0]) : '0;
  assign new_gain = change_q[PRICE_BITS] ? '0 : SUM_BITS'(change_q[PRICE_BITS-1:0]);
  assign new_loss = change_q[PRICE_BITS] ? SUM_BITS'(change_q[PRICE_BITS-1:0]) : '0;

  assign ptr_d = ((WIN_BITS'(ptr_q) + WIN_BITS'(1)) == win_q) ? '0
                                                              : ptr_q + PTR_BITS'(1);

  always_comb begin
    if (!window_full) begin
      rsi_d = '0;
    end else if (loss_q == '0) begin
      rsi_d = rsi_pkg::FULL_SCALE;
    end else begin
      rsi_d = quotient;
    end
    sig_d = rsi_pkg::SIG_NONE;
    if (window_full) begin
      if (rsi_d < oversold_q && prev_sig_q != rsi_pkg::SIG_BUY) begin
        sig_d = rsi_pkg::SIG_BUY;
      end else if (rsi_d > overbought_q && prev_sig_q != rsi_pkg::SIG_SELL) begin
        sig_d = rsi_pkg::SIG_SELL;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q        <= WIN_BITS'(WIN_RESET);
      oversold_q   <= rsi_pkg::OVERSOLD_RESET;
      overbought_q <= rsi_pkg::OVERBOUGHT_RESET;
      prev_price_q <= '0;
      ptr_q        <= '0;
      cnt_q        <= '0;
      gain_q       <= '0;
      loss_q       <= '0;
      prev_sig_q   <= rsi_pkg::SIG_NONE;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          rsi_pkg::CFG_WINDOW:     win_q        <= win_clamp;
          rsi_pkg::CFG_OVERSOLD:   oversold_q   <= cfg_data_i;
          rsi_pkg::CFG_OVERBOUGHT: overbought_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (clear) begin
        prev_price_q <= '0;
        ptr_q        <= '0;
        cnt_q        <= '0;
        gain_q       <= '0;
        loss_q       <= '0;
        prev_sig_q   <= rsi_pkg::SIG_NONE;
      end
      // The oldest change leaves the sums once the window is full.
      if (cmd_i.update && have_prev && window_full) begin
        gain_q <= gain_q - old_gain;
        loss_q <= loss_q - old_loss;
      end
      if (cmd_i.add) begin
        if (have_prev) begin
          gain_q <= gain_q + new_gain;
          loss_q <= loss_q + new_loss;
          ptr_q  <= ptr_d;
        end
        prev_price_q <= price_q;
        if (!window_full) begin
          cnt_q <= cnt_q + CNT_BITS'(1);
        end
      end
      if (cmd_i.finish && sig_d != rsi_pkg::SIG_NONE) begin
        prev_sig_q <= sig_d;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      price_q <= PRICE_BITS'(in_item_i.close_price);
    end
    if (cmd_i.update) begin
      change_q <= change_d;
    end
    if (cmd_i.finish) begin
      out_q.strength_index <= rsi_d;
      out_q.index_ready    <= window_full;
      out_q.trade_signal   <= sig_d;
    end
  end

  // Change ring: one write port and one registered read port at the ring pointer.
  always_ff @(posedge clk_i) begin
    if (cmd_i.add && have_prev) begin
      ring[ptr_q] <= change_q;
    end
    rd_q <= ring[ptr_q];
  end

  rsi_divider #(
    .SUM_BITS (SUM_BITS)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .gain_i     (gain_q),
    .loss_i     (loss_q),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  assign status_o.ready       = window_full;
  assign status_o.loss_zero   = (loss_q == '0);
  assign status_o.div_busy    = div_busy;
  assign status_o.out_blocked = out_valid_q && out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

// ----- sv/rsi_ctrl.sv -----
// Controller state machine that steps one item through the datapath.
`default_nettype none

module rsi_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire rsi_pkg::dp_status_t status_i,
  output rsi_pkg::dp_cmd_t         cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_READ   = 7'b0000010,
    ST_UPDATE = 7'b0000100,
    ST_ADD    = 7'b0001000,
    ST_CHECK  = 7'b0010000,
    ST_DIV    = 7'b0100000,
    ST_FINISH = 7'b1000000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_ADD;
      end
      ST_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = ST_CHECK;
      end
      ST_CHECK: begin
        if (status_i.ready && !status_i.loss_zero) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_DIV: begin
        if (!status_i.div_busy) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!status_i.out_blocked) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

// ----- sv/rsi_threshold_signal_core.sv -----
// Top level of the relative strength index block with threshold trade signals.
// A result is registered once its item has passed the read, update, add, check and finish
// states, with the 15-step divider run between check and finish when the window is full and
// the loss sum is nonzero. The block takes no new item until the controller is back in idle;
// the serial divider and the one-item controller set the item rate.
// Reset: rst_ni clears the history, the last signal and the output valid at once and loads
// the register defaults; the change ring needs no clearing pass.
`default_nettype none

module rsi_threshold_signal_core #(
  parameter int MAX_WINDOW = rsi_pkg::MAX_WINDOW_DEFAULT,
  parameter int PRICE_BITS = rsi_pkg::PRICE_BITS_DEFAULT
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [rsi_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  wire logic [rsi_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire rsi_pkg::in_item_t                  in_item_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output rsi_pkg::out_item_t                      out_item_o
);

  // The controller walks each item through read, update, add, check, an optional
  // division and a finish step. The datapath owns all data state, so the two are joined
  // only by the command and status structs below.
  rsi_pkg::dp_cmd_t    cmd;
  rsi_pkg::dp_status_t status;

  rsi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The result register inside the datapath lets a finished item wait for the
  // downstream side while the next item is already accepted and worked on.
  rsi_datapath #(
    .MAX_WINDOW (MAX_WINDOW),
    .PRICE_BITS (PRICE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// ----- sv/rsi_checker.sv -----
// Port-level assertions for the relative strength index block and their bind.
`default_nettype none

module rsi_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire rsi_pkg::out_item_t out_item_o
);

  // Items are worked on one at a time, so an accepted item stalls the input next cycle.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken again right after an accepted item");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("stalled result item changed or dropped");

  a_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.index_ready) |->
      (out_item_o.strength_index == '0 && out_item_o.trade_signal == rsi_pkg::SIG_NONE))
    else $error("index or signal given before the window is full");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.strength_index <= rsi_pkg::FULL_SCALE &&
      (out_item_o.trade_signal == rsi_pkg::SIG_NONE ||
       out_item_o.trade_signal == rsi_pkg::SIG_BUY ||
       out_item_o.trade_signal == rsi_pkg::SIG_SELL)))
    else $error("result item out of range");

endmodule

bind rsi_threshold_signal_core rsi_checker u_rsi_checker (.*);

`default_nettype wire
